>>> design/vrp_pkg.sv
package vrp_pkg;

  // One input word: a byte of the range string, or the end marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } char_t;

  // One result word, given once per string on the end marker.
  typedef struct packed {
    logic        ok;
    logic [3:0]  form;
    logic [31:0] major;
    logic [31:0] minor;
    logic [31:0] patch;
    logic        has_major;
    logic        has_minor;
    logic        has_patch;
  } result_t;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_LEAD,
    PH_OPSEL,
    PH_PREVER,
    PH_MAJ,
    PH_DOT1,
    PH_MIN,
    PH_DOT2,
    PH_PAT,
    PH_TRAIL
  } phase_t;

  // Parser control state that travels between the step logic and the top.
  typedef struct packed {
    phase_t     phase;
    logic [3:0] form;
    logic [2:0] part_flags;
    logic       digit_seen;
    logic       failed;
  } ctl_t;

  // Form codes.
  localparam logic [3:0] FORM_STAR  = 4'd0;
  localparam logic [3:0] FORM_CARET = 4'd1;
  localparam logic [3:0] FORM_TILDE = 4'd2;
  localparam logic [3:0] FORM_EQ    = 4'd3;
  localparam logic [3:0] FORM_GT    = 4'd4;
  localparam logic [3:0] FORM_GEQ   = 4'd5;
  localparam logic [3:0] FORM_LT    = 4'd6;
  localparam logic [3:0] FORM_LEQ   = 4'd7;
  localparam logic [3:0] FORM_BARE  = 4'd8;
  localparam logic [3:0] FORM_WILD  = 4'd9;

  // Characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam ctl_t CTL_RESET = '{
    phase:      PH_LEAD,
    form:       FORM_STAR,
    part_flags: 3'b000,
    digit_seen: 1'b0,
    failed:     1'b0
  };

endpackage

>>> design/version_range_parser.sv
// Version-range parser.
// The char channel (char_valid, char_ready, char_data) carries one word per
// byte of the range string; a word with at_end set closes the string and
// carries no byte. The res channel (res_valid, res_ready, res_data) carries
// one word per string: ok, the form code, the three version numbers and the
// flags for which parts were present. On an error every field, ok included, is zero.
// Each byte is folded into the parser state in the cycle it is accepted, so
// the block takes one word every cycle but for an end word held back. The
// result is written to the output register when the end word is accepted.
// The per-byte path is one phase decode plus a multiply by ten done as two
// shifted adds on a NUMBER_BITS wide accumulator.
// While the receiver stalls, byte words are still taken, so the next string
// is parsed while the previous result waits; only an end word waits, with
// char_ready low, until the output register is empty or drained that cycle.
// Synchronous reset returns the parser to the leading-whitespace phase with
// all numbers and flags cleared and empties the output register. After each
// end word the parser state returns to that same condition.
module version_range_parser #(
  parameter int NUMBER_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_ready,
  input  vrp_pkg::char_t   char_data,
  output logic             res_valid,
  input  logic             res_ready,
  output vrp_pkg::result_t res_data
);

  vrp_pkg::ctl_t          ctl;
  vrp_pkg::ctl_t          ctl_next;
  logic [NUMBER_BITS-1:0] major_acc;
  logic [NUMBER_BITS-1:0] minor_acc;
  logic [NUMBER_BITS-1:0] patch_acc;
  logic [NUMBER_BITS-1:0] major_next;
  logic [NUMBER_BITS-1:0] minor_next;
  logic [NUMBER_BITS-1:0] patch_next;
  logic [31:0]            major_out;
  logic [31:0]            minor_out;
  logic [31:0]            patch_out;
  logic                   ok;
  logic                   char_take;
  vrp_pkg::result_t       result;

  vrp_char_step #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_step (
    .ctl       (ctl),
    .major_acc (major_acc),
    .minor_acc (minor_acc),
    .patch_acc (patch_acc),
    .ch        (char_data.ch),
    .ctl_next  (ctl_next),
    .major_next(major_next),
    .minor_next(minor_next),
    .patch_next(patch_next)
  );

  // Numbers leave the block as 32-bit fields whatever the accumulator width.
  generate
    if (NUMBER_BITS >= 32) begin : g_trunc
      assign major_out = major_acc[31:0];
      assign minor_out = minor_acc[31:0];
      assign patch_out = patch_acc[31:0];
    end else begin : g_ext
      assign major_out = {{(32-NUMBER_BITS){1'b0}}, major_acc};
      assign minor_out = {{(32-NUMBER_BITS){1'b0}}, minor_acc};
      assign patch_out = {{(32-NUMBER_BITS){1'b0}}, patch_acc};
    end
  endgenerate

  // A string is complete after trailing whitespace, a wildcard or a lone
  // star, or while still inside a part that has at least one digit.
  assign ok = !ctl.failed &&
              ((ctl.phase == vrp_pkg::PH_TRAIL) ||
               (((ctl.phase == vrp_pkg::PH_MAJ) || (ctl.phase == vrp_pkg::PH_MIN) ||
                 (ctl.phase == vrp_pkg::PH_PAT)) && ctl.digit_seen));

  always_comb begin
    result = '0;
    if (ok) begin
      result.ok        = 1'b1;
      result.form      = ctl.form;
      result.major     = major_out;
      result.minor     = minor_out;
      result.patch     = patch_out;
      result.has_major = ctl.part_flags[0];
      result.has_minor = ctl.part_flags[1];
      result.has_patch = ctl.part_flags[2];
    end
  end

  // Only the end word needs room in the output register.
  assign char_ready = !res_valid || res_ready || !char_data.at_end;
  assign char_take  = char_valid && char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= vrp_pkg::CTL_RESET;
      major_acc <= '0;
      minor_acc <= '0;
      patch_acc <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (char_take) begin
        if (char_data.at_end) begin
          ctl       <= vrp_pkg::CTL_RESET;
          major_acc <= '0;
          minor_acc <= '0;
          patch_acc <= '0;
          res_valid <= 1'b1;
        end else begin
          ctl       <= ctl_next;
          major_acc <= major_next;
          minor_acc <= minor_next;
          patch_acc <= patch_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_take && char_data.at_end) begin
      res_data <= result;
    end
  end

endmodule

>>> design/vrp_char_step.sv
module vrp_char_step #(
  parameter int NUMBER_BITS = 32
) (
  input  vrp_pkg::ctl_t            ctl,
  input  logic [NUMBER_BITS-1:0]   major_acc,
  input  logic [NUMBER_BITS-1:0]   minor_acc,
  input  logic [NUMBER_BITS-1:0]   patch_acc,
  input  logic [7:0]               ch,
  output vrp_pkg::ctl_t            ctl_next,
  output logic [NUMBER_BITS-1:0]   major_next,
  output logic [NUMBER_BITS-1:0]   minor_next,
  output logic [NUMBER_BITS-1:0]   patch_next
);

  logic                   is_ws;
  logic                   is_dig;
  logic [1:0]             part;
  logic [NUMBER_BITS-1:0] acc_sel;
  logic [NUMBER_BITS-1:0] acc_new;
  logic                   take;

  assign is_ws  = (ch == vrp_pkg::CH_SPACE) || (ch == vrp_pkg::CH_TAB) ||
                  (ch == vrp_pkg::CH_NL);
  assign is_dig = (ch >= vrp_pkg::CH_ZERO) && (ch <= vrp_pkg::CH_NINE);

  // The part a digit would go to follows from the phase alone.
  always_comb begin
    case (ctl.phase)
      vrp_pkg::PH_MIN, vrp_pkg::PH_DOT1: part = 2'd1;
      vrp_pkg::PH_PAT, vrp_pkg::PH_DOT2: part = 2'd2;
      default:                           part = 2'd0;
    endcase
  end

  always_comb begin
    case (part)
      2'd1:    acc_sel = minor_acc;
      2'd2:    acc_sel = patch_acc;
      default: acc_sel = major_acc;
    endcase
  end

  // acc * 10 + digit as two shifts and two adds; wraps at the accumulator width.
  assign acc_new = {acc_sel[NUMBER_BITS-4:0], 3'b000} +
                   {acc_sel[NUMBER_BITS-2:0], 1'b0} +
                   {{(NUMBER_BITS-4){1'b0}}, ch[3:0]};

  always_comb begin
    ctl_next = ctl;
    take     = 1'b0;
    if (!ctl.failed) begin
      case (ctl.phase)
        vrp_pkg::PH_LEAD: begin
          if (is_ws) begin
            ctl_next.phase = vrp_pkg::PH_LEAD;
          end else if (ch == vrp_pkg::CH_STAR) begin
            ctl_next.form  = vrp_pkg::FORM_STAR;
            ctl_next.phase = vrp_pkg::PH_TRAIL;
          end else if (ch == vrp_pkg::CH_CARET) begin
            ctl_next.form  = vrp_pkg::FORM_CARET;
            ctl_next.phase = vrp_pkg::PH_PREVER;
          end else if (ch == vrp_pkg::CH_TILDE) begin
            ctl_next.form  = vrp_pkg::FORM_TILDE;
            ctl_next.phase = vrp_pkg::PH_PREVER;
          end else if (ch == vrp_pkg::CH_EQ) begin
            ctl_next.form  = vrp_pkg::FORM_EQ;
            ctl_next.phase = vrp_pkg::PH_PREVER;
          end else if (ch == vrp_pkg::CH_GT) begin
            ctl_next.form  = vrp_pkg::FORM_GT;
            ctl_next.phase = vrp_pkg::PH_OPSEL;
          end else if (ch == vrp_pkg::CH_LT) begin
            ctl_next.form  = vrp_pkg::FORM_LT;
            ctl_next.phase = vrp_pkg::PH_OPSEL;
          end else if (is_dig) begin
            ctl_next.form = vrp_pkg::FORM_BARE;
            take          = 1'b1;
          end else begin
            ctl_next.failed = 1'b1;
          end
        end
        vrp_pkg::PH_OPSEL: begin
          if (ch == vrp_pkg::CH_EQ) begin
            ctl_next.form  = (ctl.form == vrp_pkg::FORM_GT) ? vrp_pkg::FORM_GEQ
                                                            : vrp_pkg::FORM_LEQ;
            ctl_next.phase = vrp_pkg::PH_PREVER;
          end else if (is_ws) begin
            ctl_next.phase = vrp_pkg::PH_PREVER;
          end else if (is_dig) begin
            take = 1'b1;
          end else begin
            ctl_next.failed = 1'b1;
          end
        end
        vrp_pkg::PH_PREVER: begin
          if (is_dig) begin
            take = 1'b1;
          end else if (!is_ws) begin
            ctl_next.failed = 1'b1;
          end
        end
        vrp_pkg::PH_MAJ, vrp_pkg::PH_MIN, vrp_pkg::PH_PAT: begin
          if (is_dig) begin
            take = 1'b1;
          end else if (ch == vrp_pkg::CH_DOT && ctl.phase != vrp_pkg::PH_PAT) begin
            ctl_next.phase      = (ctl.phase == vrp_pkg::PH_MAJ) ? vrp_pkg::PH_DOT1
                                                                 : vrp_pkg::PH_DOT2;
            ctl_next.digit_seen = 1'b0;
          end else if (is_ws) begin
            ctl_next.phase = vrp_pkg::PH_TRAIL;
          end else begin
            ctl_next.failed = 1'b1;
          end
        end
        vrp_pkg::PH_DOT1, vrp_pkg::PH_DOT2: begin
          if (ch == vrp_pkg::CH_STAR && ctl.form == vrp_pkg::FORM_BARE) begin
            ctl_next.form  = vrp_pkg::FORM_WILD;
            ctl_next.phase = vrp_pkg::PH_TRAIL;
          end else if (is_dig) begin
            take = 1'b1;
          end else begin
            ctl_next.failed = 1'b1;
          end
        end
        vrp_pkg::PH_TRAIL: begin
          if (!is_ws) begin
            ctl_next.failed = 1'b1;
          end
        end
        default: begin
          ctl_next.failed = 1'b1;
        end
      endcase

      if (take) begin
        ctl_next.digit_seen       = 1'b1;
        ctl_next.part_flags[part] = 1'b1;
        case (part)
          2'd1:    ctl_next.phase = vrp_pkg::PH_MIN;
          2'd2:    ctl_next.phase = vrp_pkg::PH_PAT;
          default: ctl_next.phase = vrp_pkg::PH_MAJ;
        endcase
      end
    end
  end

  assign major_next = (take && part == 2'd0) ? acc_new : major_acc;
  assign minor_next = (take && part == 2'd1) ? acc_new : minor_acc;
  assign patch_next = (take && part == 2'd2) ? acc_new : patch_acc;

endmodule

>>> sim/version_range_parser_test.sv
`timescale 1ns / 1ps

module version_range_parser_test;

  // Clock, reset and the two channels of the block.
  logic             clk;
  logic             rst = 1'b1;
  logic             char_valid = 1'b0;
  logic             char_ready;
  vrp_pkg::char_t   char_data = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  vrp_pkg::result_t res_data;

  version_range_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // 2 ns period, high half first.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Words waiting to be driven, and the results the parser must give back in order.
  vrp_pkg::char_t   pending_words[$];
  vrp_pkg::result_t want_results[$];

  // A scratch string that the stimulus tasks build before it is queued.
  logic [7:0] txt[$];

  int errors        = 0;
  int words_queued  = 0;
  int words_taken   = 0;
  int strings_sent  = 0;
  int results_seen  = 0;
  int ok_seen       = 0;

  // Set by the monitor when the driver's word was accepted at a rising edge,
  // and consumed by the driver at the following falling edge.
  bit char_took = 1'b0;

  // ---------------------------------------------------------------------------
  // Predicted parser state. It mirrors what the block must hold between words
  // of one string and is cleared after every end word.
  // ---------------------------------------------------------------------------
  vrp_pkg::phase_t sp_phase;
  logic [3:0]      sp_form;
  logic [31:0]     sp_major;
  logic [31:0]     sp_minor;
  logic [31:0]     sp_patch;
  logic [2:0]      sp_parts;
  logic            sp_digit;
  logic            sp_failed;

  function automatic logic is_blank(input logic [7:0] c);
    return c == vrp_pkg::CH_SPACE || c == vrp_pkg::CH_TAB || c == vrp_pkg::CH_NL;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= vrp_pkg::CH_ZERO && c <= vrp_pkg::CH_NINE;
  endfunction

  task automatic clear_parser();
    sp_phase  = vrp_pkg::PH_LEAD;
    sp_form   = vrp_pkg::FORM_STAR;
    sp_major  = '0;
    sp_minor  = '0;
    sp_patch  = '0;
    sp_parts  = '0;
    sp_digit  = 1'b0;
    sp_failed = 1'b0;
  endtask

  // Adds one decimal digit to the given part (0 major, 1 minor, 2 patch).
  // The 32-bit accumulators wrap exactly as the block's numbers do.
  task automatic take_digit(input int part, input logic [7:0] c);
    logic [31:0] d;
    d = {24'd0, c - vrp_pkg::CH_ZERO};
    case (part)
      0: begin
        sp_major = sp_major * 32'd10 + d;
        sp_phase = vrp_pkg::PH_MAJ;
      end
      1: begin
        sp_minor = sp_minor * 32'd10 + d;
        sp_phase = vrp_pkg::PH_MIN;
      end
      default: begin
        sp_patch = sp_patch * 32'd10 + d;
        sp_phase = vrp_pkg::PH_PAT;
      end
    endcase
    sp_parts[part] = 1'b1;
    sp_digit = 1'b1;
  endtask

  // Folds one byte of the string into the predicted state. Once an error is
  // seen, every further byte is ignored until the end word.
  task automatic fold_char(input logic [7:0] c);
    int part;
    if (sp_failed) return;
    case (sp_phase)
      vrp_pkg::PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == vrp_pkg::CH_STAR) begin
            sp_form = vrp_pkg::FORM_STAR;
            sp_phase = vrp_pkg::PH_TRAIL;
          end else if (c == vrp_pkg::CH_CARET) begin
            sp_form = vrp_pkg::FORM_CARET;
            sp_phase = vrp_pkg::PH_PREVER;
          end else if (c == vrp_pkg::CH_TILDE) begin
            sp_form = vrp_pkg::FORM_TILDE;
            sp_phase = vrp_pkg::PH_PREVER;
          end else if (c == vrp_pkg::CH_EQ) begin
            sp_form = vrp_pkg::FORM_EQ;
            sp_phase = vrp_pkg::PH_PREVER;
          end else if (c == vrp_pkg::CH_GT) begin
            sp_form = vrp_pkg::FORM_GT;
            sp_phase = vrp_pkg::PH_OPSEL;
          end else if (c == vrp_pkg::CH_LT) begin
            sp_form = vrp_pkg::FORM_LT;
            sp_phase = vrp_pkg::PH_OPSEL;
          end else if (is_digit(c)) begin
            sp_form = vrp_pkg::FORM_BARE;
            take_digit(0, c);
          end else begin
            sp_failed = 1'b1;
          end
        end
      end
      vrp_pkg::PH_OPSEL: begin
        // A '=' right after '>' or '<' turns it into the inclusive form.
        if (c == vrp_pkg::CH_EQ) begin
          sp_form = (sp_form == vrp_pkg::FORM_GT) ? vrp_pkg::FORM_GEQ : vrp_pkg::FORM_LEQ;
          sp_phase = vrp_pkg::PH_PREVER;
        end else if (is_blank(c)) begin
          sp_phase = vrp_pkg::PH_PREVER;
        end else if (is_digit(c)) begin
          take_digit(0, c);
        end else begin
          sp_failed = 1'b1;
        end
      end
      vrp_pkg::PH_PREVER: begin
        if (is_digit(c)) begin
          take_digit(0, c);
        end else if (!is_blank(c)) begin
          sp_failed = 1'b1;
        end
      end
      vrp_pkg::PH_MAJ, vrp_pkg::PH_MIN, vrp_pkg::PH_PAT: begin
        part = (sp_phase == vrp_pkg::PH_MAJ) ? 0 : (sp_phase == vrp_pkg::PH_MIN) ? 1 : 2;
        if (is_digit(c)) begin
          take_digit(part, c);
        end else if (c == vrp_pkg::CH_DOT && part < 2) begin
          sp_phase = (part == 0) ? vrp_pkg::PH_DOT1 : vrp_pkg::PH_DOT2;
          sp_digit = 1'b0;
        end else if (is_blank(c)) begin
          sp_phase = vrp_pkg::PH_TRAIL;
        end else begin
          sp_failed = 1'b1;
        end
      end
      vrp_pkg::PH_DOT1, vrp_pkg::PH_DOT2: begin
        // The wildcard part is only legal on a version with no operator.
        if (c == vrp_pkg::CH_STAR && sp_form == vrp_pkg::FORM_BARE) begin
          sp_form = vrp_pkg::FORM_WILD;
          sp_phase = vrp_pkg::PH_TRAIL;
        end else if (is_digit(c)) begin
          take_digit((sp_phase == vrp_pkg::PH_DOT1) ? 1 : 2, c);
        end else begin
          sp_failed = 1'b1;
        end
      end
      vrp_pkg::PH_TRAIL: begin
        if (!is_blank(c)) sp_failed = 1'b1;
      end
      default: sp_failed = 1'b1;
    endcase
  endtask

  // The end word: decide ok, queue the result and start a fresh string.
  // An error result carries zeros in every field.
  task automatic close_string();
    vrp_pkg::result_t r;
    logic             good;
    good = !sp_failed &&
           (sp_phase == vrp_pkg::PH_TRAIL ||
            ((sp_phase == vrp_pkg::PH_MAJ || sp_phase == vrp_pkg::PH_MIN ||
              sp_phase == vrp_pkg::PH_PAT) && sp_digit));
    r = '0;
    if (good) begin
      r.ok        = 1'b1;
      r.form      = sp_form;
      r.major     = sp_major;
      r.minor     = sp_minor;
      r.patch     = sp_patch;
      r.has_major = sp_parts[0];
      r.has_minor = sp_parts[1];
      r.has_patch = sp_parts[2];
    end
    want_results.push_back(r);
    clear_parser();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: result %0d field %s expected %0d (0x%0h) got %0d (0x%0h)",
               $time, results_seen, name, want, want, got, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. An accepted char word
  // goes through the predictor; an accepted result word is checked against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    vrp_pkg::result_t want;
    if (!rst) begin
      if (char_valid && char_ready) begin
        char_took = 1'b1;
        words_taken++;
        if (char_data.at_end) close_string();
        else fold_char(char_data.ch);
      end
      if (res_valid && res_ready) begin
        if (want_results.size() == 0) begin
          errors++;
          $display("%0t ns: result word with nothing expected, got 0x%0h", $time, res_data);
        end else begin
          want = want_results.pop_front();
          compare_field("ok",        32'(want.ok),        32'(res_data.ok));
          compare_field("form",      32'(want.form),      32'(res_data.form));
          compare_field("major",     want.major,          res_data.major);
          compare_field("minor",     want.minor,          res_data.minor);
          compare_field("patch",     want.patch,          res_data.patch);
          compare_field("has_major", 32'(want.has_major), 32'(res_data.has_major));
          compare_field("has_minor", 32'(want.has_minor), 32'(res_data.has_minor));
          compare_field("has_patch", 32'(want.has_patch), 32'(res_data.has_patch));
          if (want.ok) ok_seen++;
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: at each falling edge it either holds a word that has not been
  // taken yet, idles during a gap, or puts up the next pending word. Words
  // come out in bursts of random length separated by random gaps; a gap of
  // zero lets bursts run back to back.
  // ---------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (char_valid && !char_took) begin
        // Word still on offer: payload and valid stay as they are.
      end else if (gap_left > 0) begin
        gap_left--;
        char_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        char_data  <= pending_words.pop_front();
        char_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        char_valid <= 1'b0;
      end
      char_took = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: res_ready follows a stall pattern chosen at random from always
  // ready, coin flips, ready a quarter of the time, and long holds.
  // ---------------------------------------------------------------------------
  int stall_mode  = 0;
  int stall_cycle = 0;
  int stall_hold  = 0;

  always @(negedge clk) begin
    logic ready_next;
    stall_cycle++;
    if (stall_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: ready_next = 1'b1;
      1: ready_next = 1'($urandom_range(0, 1));
      2: ready_next = (stall_cycle % 4 == 0);
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          ready_next = 1'b0;
        end else begin
          ready_next = 1'b1;
          stall_hold = $urandom_range(0, 12);
        end
      end
    endcase
    res_ready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] c, input logic last);
    vrp_pkg::char_t w;
    w.ch     = c;
    w.at_end = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Queues the scratch string followed by an end word with a random byte,
  // which the parser must ignore.
  task automatic send_txt();
    foreach (txt[i]) push_word(txt[i], 1'b0);
    push_word(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    txt.delete();
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_txt();
  endtask

  task automatic add_blanks(input int lo, input int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: txt.push_back(vrp_pkg::CH_SPACE);
        1: txt.push_back(vrp_pkg::CH_TAB);
        default: txt.push_back(vrp_pkg::CH_NL);
      endcase
    end
  endtask

  // Mostly short numbers; now and then a long one that can wrap past 32 bits.
  task automatic add_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    repeat (n) txt.push_back(vrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Builds a well-formed range expression in the scratch string.
  task automatic build_wellformed();
    int op;
    int parts;
    txt.delete();
    if ($urandom_range(0, 3) == 0) add_blanks(1, 3);
    op = $urandom_range(0, 9);
    case (op)
      0: txt.push_back(vrp_pkg::CH_STAR);
      1: txt.push_back(vrp_pkg::CH_CARET);
      2: txt.push_back(vrp_pkg::CH_TILDE);
      3: txt.push_back(vrp_pkg::CH_EQ);
      4: txt.push_back(vrp_pkg::CH_GT);
      5: begin
        txt.push_back(vrp_pkg::CH_GT);
        txt.push_back(vrp_pkg::CH_EQ);
      end
      6: txt.push_back(vrp_pkg::CH_LT);
      7: begin
        txt.push_back(vrp_pkg::CH_LT);
        txt.push_back(vrp_pkg::CH_EQ);
      end
      default: ;
    endcase
    if (op != 0) begin
      if (op < 8 && $urandom_range(0, 3) == 0) add_blanks(1, 2);
      parts = $urandom_range(1, 3);
      for (int p = 0; p < parts; p++) begin
        if (p > 0) txt.push_back(vrp_pkg::CH_DOT);
        add_number();
      end
      // Bare versions may close with a wildcard part.
      if (op >= 8 && parts < 3 && $urandom_range(0, 2) == 0) begin
        txt.push_back(vrp_pkg::CH_DOT);
        txt.push_back(vrp_pkg::CH_STAR);
      end
    end
    if ($urandom_range(0, 3) == 0) add_blanks(1, 3);
  endtask

  // Breaks a string by replacing, dropping or inserting one byte. The new byte
  // is often one the grammar cares about, so the damage lands near the edges
  // of legal input.
  task automatic mutate_txt();
    int         pos;
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = vrp_pkg::CH_DOT;
      1: b = vrp_pkg::CH_STAR;
      2: b = vrp_pkg::CH_EQ;
      3: b = vrp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      4: b = vrp_pkg::CH_SPACE;
      5: b = vrp_pkg::CH_GT;
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (txt.size() == 0) begin
      txt.push_back(b);
    end else begin
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 2))
        0: txt[pos] = b;
        1: txt.delete(pos);
        default: txt.insert(pos, b);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    int n;
    int start_words;

    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: every form, the largest and a wrapping number,
    // blanks around the expression, and the usual ways to get it wrong.
    send_text("*");
    send_text(" \t\n^1.2.3 \t\n");
    send_text("~ 0");
    send_text("=9");
    send_text("> 1");
    send_text(">=2.0");
    send_text("<3");
    send_text("<=4294967295");
    send_text("4294967296.7.99");
    send_text("1.*");
    send_text("1.2.*\t");
    send_text("^1.*");
    send_text("");
    send_text("  ");
    send_text("1.");
    send_text("1.2.3.4");
    send_text("*1");
    send_text("> =1");
    txt.delete();
    txt.push_back(8'h00);
    txt.push_back(vrp_pkg::CH_ZERO);
    send_txt();
    txt.delete();
    txt.push_back(vrp_pkg::CH_ZERO + 8'd5);
    txt.push_back(8'hFF);
    send_txt();

    // Random strings: mostly well formed with random content, the rest broken
    // or pure noise.
    start_words = words_queued;
    while (words_queued - start_words < 1550) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        build_wellformed();
      end else if (kind < 88) begin
        build_wellformed();
        mutate_txt();
      end else if (kind < 96) begin
        txt.delete();
        n = $urandom_range(0, 8);
        repeat (n) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        txt.delete();
        add_blanks(0, 3);
      end
      send_txt();
    end

    // Drain: all words taken and every result back, then a quiet wait to catch
    // any stray result word.
    while (pending_words.size() != 0 || char_valid || want_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d strings in %0d words; %0d results checked, %0d well formed.",
             strings_sent, words_taken, results_seen, ok_seen);
    if (errors == 0) begin
      $display("PASS version_range_parser");
    end else begin
      $display("%0d mismatches.", errors);
      $display("FAIL version_range_parser");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", want_results.size());
    $display("FAIL version_range_parser");
    $finish;
  end

endmodule

>>> version_range_parser.f
design/vrp_pkg.sv
design/vrp_char_step.sv
design/version_range_parser.sv
sim/version_range_parser_test.sv
